// ===== rtl/ehc_pkg.sv =====
// Shared types, codes and constants for the encoder axis homing controller.
package ehc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int DUTY_W          = 10;
	localparam int TRACK_W         = 16;
	localparam int MARGIN_W        = 8;
	localparam int WIN_W           = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;
	localparam int OUT_W           = 32;

	localparam logic [DUTY_W-1:0]   DUTY_RST   = 10'd512;
	localparam logic [TRACK_W-1:0]  TRACK_RST  = 16'd100;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd3;
	localparam logic [WIN_W-1:0]    WIN_RST    = 16'd200;

	typedef enum logic [2:0] {
		ACT_SAMPLE = 3'd0,
		ACT_CAL    = 3'd1,
		ACT_FWD    = 3'd2,
		ACT_BACK   = 3'd3,
		ACT_BRAKE  = 3'd4,
		ACT_COAST  = 3'd5,
		ACT_ZERO   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		MODE_COAST = 2'd0,
		MODE_FWD   = 2'd1,
		MODE_BACK  = 2'd2,
		MODE_BRAKE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_UNCAL    = 3'd0,
		PH_SEEK_MIN = 3'd1,
		PH_SEEK_MAX = 3'd2,
		PH_RETURN   = 3'd3,
		PH_READY    = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIVE_DUTY = 2'd0,
		CFG_TRACK_CM   = 2'd1,
		CFG_MARGIN_CM  = 2'd2,
		CFG_WIN_TICKS  = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CS_IDLE = 3'd0,
		CS_MUL  = 3'd1,
		CS_DIV  = 3'd2,
		CS_LIM  = 3'd3,
		CS_FLAG = 3'd4
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic set_limits;
		logic finish;
	} ehc_cmd_t;

	typedef struct packed {
		logic needs_div;
		logic div_busy;
	} ehc_status_t;

endpackage

// ===== rtl/ehc_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module ehc_div #(
	parameter int NW = 40,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;

	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den};
	assign ge    = ~diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/ehc_dp.sv =====
// Datapath: encoder count, calibration phase, speed window, limits and result register.
module ehc_dp #(
	parameter int CW = ehc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ehc_pkg::ehc_cmd_t                  cmd,
	output ehc_pkg::ehc_status_t               status,
	input  logic                               cfg_wr_en,
	input  logic [ehc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ehc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [2:0]                         action,
	input  logic                               enc_a,
	input  logic                               enc_b,
	input  logic                               min_sensor,
	input  logic                               max_sensor,
	output logic                               dir_first,
	output logic                               dir_second,
	output logic [ehc_pkg::DUTY_W-1:0]         pwm_duty,
	output logic signed [ehc_pkg::OUT_W-1:0]   pulse_count,
	output logic signed [ehc_pkg::OUT_W-1:0]   window_delta,
	output logic                               forward_limit,
	output logic                               backward_limit,
	output logic [2:0]                         calib_state,
	output logic signed [ehc_pkg::OUT_W-1:0]   track_pulses
);

	localparam int NW = CW + ehc_pkg::MARGIN_W;
	localparam int SW = (CW + 4 > 65) ? CW + 4 : 65;

	localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] ONE     = CW'(1);
	localparam logic [NW-1:0] LIM_P = {{(ehc_pkg::MARGIN_W+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [NW-1:0] LIM_N = {{ehc_pkg::MARGIN_W{1'b0}}, 1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] S64_MAX = SW'(64'sh7FFF_FFFF_FFFF_FFFF);
	localparam logic signed [SW-1:0] S64_MIN = SW'($signed(64'h8000_0000_0000_0000));
	localparam logic signed [SW-1:0] O32_MAX = SW'(32'sh7FFF_FFFF);
	localparam logic signed [SW-1:0] O32_MIN = SW'($signed(32'h8000_0000));
	localparam logic signed [SW-1:0] K2 = SW'(2);
	localparam logic signed [SW-1:0] K5 = SW'(5);
	localparam logic signed [SW-1:0] K6 = SW'(6);

	function automatic logic signed [SW-1:0] sx(input logic signed [CW-1:0] v);
		return SW'(v);
	endfunction

	function automatic logic signed [SW-1:0] sat64(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = v;
		if (v > S64_MAX) r = S64_MAX;
		if (v < S64_MIN) r = S64_MIN;
		return r;
	endfunction

	function automatic logic [ehc_pkg::OUT_W-1:0] out32(input logic signed [SW-1:0] v);
		logic [ehc_pkg::OUT_W-1:0] r;
		r = v[ehc_pkg::OUT_W-1:0];
		if (v > O32_MAX) r = 32'h7FFF_FFFF;
		if (v < O32_MIN) r = 32'h8000_0000;
		return r;
	endfunction

	// configuration
	logic [ehc_pkg::DUTY_W-1:0]   drive_duty_q;
	logic [ehc_pkg::TRACK_W-1:0]  track_cm_q;
	logic [ehc_pkg::MARGIN_W-1:0] margin_cm_q;
	logic [ehc_pkg::WIN_W-1:0]    win_ticks_q;

	// architectural state
	logic signed [CW-1:0] pos_q, meas_q, lower_q, upper_q, win_start_q;
	logic signed [CW:0]   delta_q;
	logic                 prev_a_q, primed_q;
	ehc_pkg::phase_t      phase_q;
	ehc_pkg::mode_t       mode_q;
	logic [ehc_pkg::WIN_W-1:0] win_cnt_q;

	// result register
	logic                       dir_first_q, dir_second_q, fwd_lim_q, bwd_lim_q;
	logic [ehc_pkg::DUTY_W-1:0] duty_q;
	logic [ehc_pkg::OUT_W-1:0]  count_out_q, delta_out_q, track_out_q;
	logic [2:0]                 phase_out_q;

	// next-state values for one tick
	logic signed [CW-1:0] pos_n, meas_n, win_start_n;
	logic signed [CW:0]   delta_n;
	ehc_pkg::phase_t      phase_a, phase_n;
	ehc_pkg::mode_t       mode_n;
	logic [ehc_pkg::WIN_W-1:0] win_cnt_n, cnt_inc, wt;
	logic                 needs_div;
	logic [ehc_pkg::DUTY_W-1:0] duty_n;
	logic                 ret_half;

	always_comb begin
		pos_n     = pos_q;
		meas_n    = meas_q;
		phase_a   = phase_q;
		mode_n    = mode_q;
		needs_div = 1'b0;

		if (primed_q && enc_a && !prev_a_q) begin
			if (enc_b) begin
				if (pos_q != CNT_MIN) pos_n = pos_q - ONE;
			end else begin
				if (pos_q != CNT_MAX) pos_n = pos_q + ONE;
			end
		end

		case (ehc_pkg::action_t'(action))
			ehc_pkg::ACT_CAL: phase_a = ehc_pkg::PH_SEEK_MIN;
			ehc_pkg::ACT_FWD, ehc_pkg::ACT_BACK, ehc_pkg::ACT_BRAKE, ehc_pkg::ACT_COAST: begin
				if (phase_q inside {ehc_pkg::PH_SEEK_MIN, ehc_pkg::PH_SEEK_MAX,
						ehc_pkg::PH_RETURN}) begin
					phase_a = ehc_pkg::PH_UNCAL;
				end
				case (ehc_pkg::action_t'(action))
					ehc_pkg::ACT_FWD:   mode_n = ehc_pkg::MODE_FWD;
					ehc_pkg::ACT_BACK:  mode_n = ehc_pkg::MODE_BACK;
					ehc_pkg::ACT_BRAKE: mode_n = ehc_pkg::MODE_BRAKE;
					default:            mode_n = ehc_pkg::MODE_COAST;
				endcase
			end
			ehc_pkg::ACT_ZERO: pos_n = '0;
			default: ;
		endcase

		phase_n = phase_a;
		case (phase_a)
			ehc_pkg::PH_SEEK_MIN: begin
				if (min_sensor) begin
					mode_n  = ehc_pkg::MODE_BRAKE;
					pos_n   = '0;
					phase_n = ehc_pkg::PH_SEEK_MAX;
				end else begin
					mode_n = ehc_pkg::MODE_BACK;
				end
			end
			ehc_pkg::PH_SEEK_MAX: begin
				if (max_sensor) begin
					mode_n = ehc_pkg::MODE_BRAKE;
					meas_n = pos_n;
					if (pos_n == '0 || track_cm_q == '0) begin
						phase_n = ehc_pkg::PH_ERROR;
					end else begin
						// limits follow once the margin division completes
						needs_div = 1'b1;
						phase_n   = ehc_pkg::PH_RETURN;
					end
				end else begin
					mode_n = ehc_pkg::MODE_FWD;
				end
			end
			ehc_pkg::PH_RETURN: begin
				if (sx(pos_n) < sat64(sx(lower_q) * K2)) begin
					mode_n  = ehc_pkg::MODE_BRAKE;
					phase_n = ehc_pkg::PH_READY;
				end else begin
					mode_n = ehc_pkg::MODE_BACK;
				end
			end
			default: ;
		endcase
	end

	// speed window
	always_comb begin
		wt          = (win_ticks_q == '0) ? ehc_pkg::WIN_W'(1) : win_ticks_q;
		cnt_inc     = win_cnt_q + ehc_pkg::WIN_W'(1);
		win_cnt_n   = cnt_inc;
		win_start_n = win_start_q;
		delta_n     = delta_q;
		if (cnt_inc >= wt) begin
			delta_n     = $signed({pos_n[CW-1], pos_n} - {win_start_q[CW-1], win_start_q});
			win_start_n = pos_n;
			win_cnt_n   = '0;
		end
	end

	always_comb begin
		ret_half = (sx(pos_n) < sat64(sx(lower_q) * K6)) ||
			(sx(pos_n) < sat64(sx(upper_q) - sat64(sx(lower_q) * K5)));
		case (mode_n)
			ehc_pkg::MODE_FWD:  duty_n = drive_duty_q;
			ehc_pkg::MODE_BACK: begin
				if (phase_n == ehc_pkg::PH_RETURN && ret_half) duty_n = drive_duty_q >> 1;
				else duty_n = drive_duty_q;
			end
			default: duty_n = '0;
		endcase
	end

	// limit flags: after an ordinary tick from the new count, after calibration from the held one
	logic signed [CW-1:0] p_sel;
	logic                 fwd_n, bwd_n;
	always_comb begin
		p_sel = cmd.finish ? pos_q : pos_n;
		fwd_n = sx(p_sel) > sat64(sx(upper_q) - sx(lower_q));
		bwd_n = sx(p_sel) < sat64(sx(lower_q) * K2);
	end

	// margin: margin_cm * |track| / track_cm, clamped, sign restored
	logic [CW-1:0]        mag;
	logic [NW-1:0]        num, quo, qlim;
	logic                 div_busy;
	logic signed [CW-1:0] lower_calc, upper_calc;
	logic signed [CW:0]   span;

	assign mag = meas_q[CW-1] ? CW'(-meas_q) : CW'(meas_q);
	assign num = NW'(mag) * NW'(margin_cm_q);

	ehc_div #(
		.NW(NW),
		.DW(ehc_pkg::TRACK_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start_div),
		.num   (num),
		.den   (track_cm_q),
		.busy  (div_busy),
		.quo   (quo)
	);

	always_comb begin
		if (meas_q[CW-1]) begin
			qlim       = (quo > LIM_N) ? LIM_N : quo;
			lower_calc = CW'(~qlim + NW'(1));
		end else begin
			qlim       = (quo > LIM_P) ? LIM_P : quo;
			lower_calc = CW'(qlim);
		end
		span = $signed({meas_q[CW-1], meas_q} - {lower_calc[CW-1], lower_calc});
		if (span[CW] != span[CW-1]) upper_calc = span[CW] ? CNT_MIN : CNT_MAX;
		else upper_calc = span[CW-1:0];
	end

	assign status.needs_div = needs_div;
	assign status.div_busy  = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_duty_q <= ehc_pkg::DUTY_RST;
			track_cm_q   <= ehc_pkg::TRACK_RST;
			margin_cm_q  <= ehc_pkg::MARGIN_RST;
			win_ticks_q  <= ehc_pkg::WIN_RST;
		end else if (cfg_wr_en) begin
			case (ehc_pkg::cfg_idx_t'(cfg_index))
				ehc_pkg::CFG_DRIVE_DUTY: drive_duty_q <= cfg_data[ehc_pkg::DUTY_W-1:0];
				ehc_pkg::CFG_TRACK_CM:   track_cm_q   <= cfg_data[ehc_pkg::TRACK_W-1:0];
				ehc_pkg::CFG_MARGIN_CM:  margin_cm_q  <= cfg_data[ehc_pkg::MARGIN_W-1:0];
				ehc_pkg::CFG_WIN_TICKS:  win_ticks_q  <= cfg_data[ehc_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			meas_q      <= '0;
			lower_q     <= '0;
			upper_q     <= '0;
			win_start_q <= '0;
			delta_q     <= '0;
			prev_a_q    <= 1'b0;
			primed_q    <= 1'b0;
			phase_q     <= ehc_pkg::PH_UNCAL;
			mode_q      <= ehc_pkg::MODE_COAST;
			win_cnt_q   <= '0;
		end else if (cmd.accept) begin
			pos_q       <= pos_n;
			meas_q      <= meas_n;
			win_start_q <= win_start_n;
			delta_q     <= delta_n;
			prev_a_q    <= enc_a;
			primed_q    <= 1'b1;
			phase_q     <= phase_n;
			mode_q      <= mode_n;
			win_cnt_q   <= win_cnt_n;
		end else if (cmd.set_limits) begin
			lower_q <= lower_calc;
			upper_q <= upper_calc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dir_first_q  <= (mode_n == ehc_pkg::MODE_FWD) || (mode_n == ehc_pkg::MODE_BRAKE);
			dir_second_q <= (mode_n == ehc_pkg::MODE_BACK) || (mode_n == ehc_pkg::MODE_BRAKE);
			duty_q       <= duty_n;
			count_out_q  <= out32(sx(pos_n));
			delta_out_q  <= out32(SW'(delta_n));
			track_out_q  <= out32(sx(meas_n));
			phase_out_q  <= phase_n;
		end
		if (cmd.accept || cmd.finish) begin
			fwd_lim_q <= fwd_n;
			bwd_lim_q <= bwd_n;
		end
	end

	assign dir_first      = dir_first_q;
	assign dir_second     = dir_second_q;
	assign pwm_duty       = duty_q;
	assign pulse_count    = $signed(count_out_q);
	assign window_delta   = $signed(delta_out_q);
	assign forward_limit  = fwd_lim_q;
	assign backward_limit = bwd_lim_q;
	assign calib_state    = phase_out_q;
	assign track_pulses   = $signed(track_out_q);

endmodule

// ===== rtl/ehc_ctrl.sv =====
// Controller: handshakes, result valid and the calibration-end sequencing.
module ehc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  ehc_pkg::ehc_status_t  status,
	output ehc_pkg::ehc_cmd_t     cmd
);

	ehc_pkg::ctrl_state_t state_q, state_n;
	logic                 out_valid_q;
	logic                 accept, load;

	assign in_stall = (state_q != ehc_pkg::CS_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ehc_pkg::CS_IDLE: if (accept && status.needs_div) state_n = ehc_pkg::CS_MUL;
			ehc_pkg::CS_MUL:  state_n = ehc_pkg::CS_DIV;
			ehc_pkg::CS_DIV:  if (!status.div_busy) state_n = ehc_pkg::CS_LIM;
			ehc_pkg::CS_LIM:  state_n = ehc_pkg::CS_FLAG;
			ehc_pkg::CS_FLAG: state_n = ehc_pkg::CS_IDLE;
			default:          state_n = ehc_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept     = accept;
		cmd.start_div  = (state_q == ehc_pkg::CS_MUL);
		cmd.set_limits = (state_q == ehc_pkg::CS_LIM);
		cmd.finish     = (state_q == ehc_pkg::CS_FLAG);
		load           = (accept && !status.needs_div) || cmd.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ehc_pkg::CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> status.div_busy)
		else $error("divider not busy after start");
	a_cal_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && status.needs_div) |=> (state_q == ehc_pkg::CS_MUL))
		else $error("calibration end did not enter multiply step");
	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ehc_pkg::CS_IDLE) |-> !out_valid_q)
		else $error("result pending while calibration sequence runs");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("calibration result not presented");
`endif

endmodule

// ===== rtl/encoder_axis_homing_controller.sv =====
// An ordinary transaction's result is registered on acceptance and is valid in the next cycle.
// Throughput: one transaction per cycle while the output side takes results.
// A calibration tick that meets the max switch with nonzero count and track_cm holds
// the input through the multiply, margin divide (one bit a cycle), limit and flag steps.
// Reset (arst_n low, asynchronous): count, limits, window and phase clear, drive coasts,
// registers return to their defaults; no clearing pass.
module encoder_axis_homing_controller #(
	parameter int COUNT_WIDTH = ehc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ehc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ehc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         action,
	input  logic                               enc_a,
	input  logic                               enc_b,
	input  logic                               min_sensor,
	input  logic                               max_sensor,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               dir_first,
	output logic                               dir_second,
	output logic [ehc_pkg::DUTY_W-1:0]         pwm_duty,
	output logic signed [ehc_pkg::OUT_W-1:0]   pulse_count,
	output logic signed [ehc_pkg::OUT_W-1:0]   window_delta,
	output logic                               forward_limit,
	output logic                               backward_limit,
	output logic [2:0]                         calib_state,
	output logic signed [ehc_pkg::OUT_W-1:0]   track_pulses
);

	ehc_pkg::ehc_cmd_t    cmd;
	ehc_pkg::ehc_status_t status;

	ehc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ehc_dp #(
		.CW(COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.enc_a         (enc_a),
		.enc_b         (enc_b),
		.min_sensor    (min_sensor),
		.max_sensor    (max_sensor),
		.dir_first     (dir_first),
		.dir_second    (dir_second),
		.pwm_duty      (pwm_duty),
		.pulse_count   (pulse_count),
		.window_delta  (window_delta),
		.forward_limit (forward_limit),
		.backward_limit(backward_limit),
		.calib_state   (calib_state),
		.track_pulses  (track_pulses)
	);

endmodule

// ===== tb/ehc_axis_checker.sv =====
// Checker for the encoder axis homing controller: tracks config, predicts each tick, compares.
`timescale 1ns / 100ps

module ehc_axis_checker
	import ehc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [2:0]                  action,
	input  logic                        enc_a,
	input  logic                        enc_b,
	input  logic                        min_sensor,
	input  logic                        max_sensor,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        dir_first,
	input  logic                        dir_second,
	input  logic [DUTY_W-1:0]           pwm_duty,
	input  logic signed [OUT_W-1:0]     pulse_count,
	input  logic signed [OUT_W-1:0]     window_delta,
	input  logic                        forward_limit,
	input  logic                        backward_limit,
	input  logic [2:0]                  calib_state,
	input  logic signed [OUT_W-1:0]     track_pulses,
	output int                          mismatches,
	output int                          pending,
	output int                          results_seen,
	output int                          homed_runs,
	output int                          calib_faults
);

	localparam longint CNT_MAX = 64'sd2147483647;
	localparam longint CNT_MIN = -CNT_MAX - 64'sd1;
	localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint I64_MIN = -I64_MAX - 64'sd1;

	typedef struct packed {
		logic               dir_f;
		logic               dir_s;
		logic [DUTY_W-1:0]  duty;
		logic [OUT_W-1:0]   count;
		logic [OUT_W-1:0]   delta;
		logic               fwd_lim;
		logic               back_lim;
		logic [2:0]         phase;
		logic [OUT_W-1:0]   track;
	} axis_out_t;

	axis_out_t expected_q[$];

	// configuration copy
	logic [DUTY_W-1:0]   cfg_duty;
	logic [TRACK_W-1:0]  cfg_track;
	logic [MARGIN_W-1:0] cfg_margin;
	logic [WIN_W-1:0]    cfg_window;

	// axis state
	longint   pos, track_p, lo_lim, hi_lim, win_start, win_delta;
	bit       prev_a, primed;
	phase_t   phase;
	mode_t    mode;
	bit [15:0] win_cnt;

	int err_i, checked_i, homed_i, fault_i;

	function automatic longint clamp_count(longint x);
		if (x > CNT_MAX) return CNT_MAX;
		if (x < CNT_MIN) return CNT_MIN;
		return x;
	endfunction

	function automatic longint sat_diff(longint a, longint b);
		if (b < 0 && a > I64_MAX + b) return I64_MAX;
		if (b > 0 && a < I64_MIN + b) return I64_MIN;
		return a - b;
	endfunction

	function automatic longint sat_scale(longint a, longint k);
		if (a > I64_MAX / k) return I64_MAX;
		if (a < I64_MIN / k) return I64_MIN;
		return a * k;
	endfunction

	function automatic logic [OUT_W-1:0] to_out(longint x);
		longint y;
		y = clamp_count(x);
		return y[OUT_W-1:0];
	endfunction

	// margin_cm * pulses / track_cm, truncated toward zero
	function automatic longint margin_of(longint pulses);
		bit neg;
		longint unsigned mag, t, m, q, r, tot, lim;
		neg = pulses < 0;
		mag = neg ? longint'(-pulses) : longint'(pulses);
		t = longint'(cfg_track);
		m = longint'(cfg_margin);
		q = mag / t;
		r = mag % t;
		tot = q * m + (r * m) / t;
		lim = neg ? CNT_MAX + 1 : CNT_MAX;
		if (tot > lim) tot = lim;
		return neg ? -longint'(tot) : longint'(tot);
	endfunction

	function automatic bit near_back_end();
		return pos < sat_scale(lo_lim, 2);
	endfunction

	function automatic axis_out_t advance_axis(logic [2:0] act, logic a, logic b, logic mn,
			logic mx);
		axis_out_t r;
		logic [DUTY_W-1:0] duty;
		logic [WIN_W-1:0] wt;
		if (primed) begin
			if (a && !prev_a)
				pos = clamp_count(b ? pos - 1 : pos + 1);
		end else begin
			primed = 1'b1;
		end
		prev_a = a;

		case (act)
			ACT_CAL: phase = PH_SEEK_MIN;
			ACT_FWD, ACT_BACK, ACT_BRAKE, ACT_COAST: begin
				// manual drive aborts a homing run in progress
				if (phase == PH_SEEK_MIN || phase == PH_SEEK_MAX || phase == PH_RETURN)
					phase = PH_UNCAL;
				case (act)
					ACT_FWD:   mode = MODE_FWD;
					ACT_BACK:  mode = MODE_BACK;
					ACT_BRAKE: mode = MODE_BRAKE;
					default:   mode = MODE_COAST;
				endcase
			end
			ACT_ZERO: pos = 0;
			default: ;
		endcase

		case (phase)
			PH_SEEK_MIN: begin
				if (mn) begin
					mode = MODE_BRAKE;
					pos = 0;
					phase = PH_SEEK_MAX;
				end else begin
					mode = MODE_BACK;
				end
			end
			PH_SEEK_MAX: begin
				if (mx) begin
					mode = MODE_BRAKE;
					track_p = pos;
					if (track_p == 0 || cfg_track == 0) begin
						phase = PH_ERROR;
						fault_i++;
					end else begin
						lo_lim = margin_of(track_p);
						hi_lim = clamp_count(sat_diff(track_p, lo_lim));
						phase = PH_RETURN;
					end
				end else begin
					mode = MODE_FWD;
				end
			end
			PH_RETURN: begin
				if (near_back_end()) begin
					mode = MODE_BRAKE;
					phase = PH_READY;
					homed_i++;
				end else begin
					mode = MODE_BACK;
				end
			end
			default: ;
		endcase

		wt = (cfg_window == 0) ? 1 : cfg_window;
		win_cnt = win_cnt + 1;
		if (win_cnt >= wt) begin
			win_delta = sat_diff(pos, win_start);
			win_start = pos;
			win_cnt = 0;
		end

		duty = '0;
		if (mode == MODE_FWD) begin
			duty = cfg_duty;
		end else if (mode == MODE_BACK) begin
			duty = cfg_duty;
			// slow down on the way home once below 6*lo_lim or below hi_lim - 5*lo_lim
			if (phase == PH_RETURN && (pos < sat_scale(lo_lim, 6) ||
					pos < sat_diff(hi_lim, sat_scale(lo_lim, 5))))
				duty = cfg_duty >> 1;
		end

		r.dir_f    = (mode == MODE_FWD || mode == MODE_BRAKE);
		r.dir_s    = (mode == MODE_BACK || mode == MODE_BRAKE);
		r.duty     = duty;
		r.count    = to_out(pos);
		r.delta    = to_out(win_delta);
		r.fwd_lim  = pos > sat_diff(hi_lim, lo_lim);
		r.back_lim = near_back_end();
		r.phase    = phase;
		r.track    = to_out(track_p);
		return r;
	endfunction

	task automatic clear_model();
		cfg_duty   = DUTY_RST;
		cfg_track  = TRACK_RST;
		cfg_margin = MARGIN_RST;
		cfg_window = WIN_RST;
		pos = 0;
		track_p = 0;
		lo_lim = 0;
		hi_lim = 0;
		win_start = 0;
		win_delta = 0;
		prev_a = 1'b0;
		primed = 1'b0;
		phase = PH_UNCAL;
		mode = MODE_COAST;
		win_cnt = '0;
		err_i = 0;
		checked_i = 0;
		homed_i = 0;
		fault_i = 0;
		expected_q.delete();
	endtask

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_i++;
	endtask

	task automatic check_field(string name, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
		if (got !== want)
			report($sformatf("result %0d %s got %0d expected %0d", checked_i, name,
				$signed(got), $signed(want)));
	endtask

	task automatic compare_result(axis_out_t want);
		check_field("dir_first", 32'(dir_first), 32'(want.dir_f));
		check_field("dir_second", 32'(dir_second), 32'(want.dir_s));
		check_field("pwm_duty", 32'(pwm_duty), 32'(want.duty));
		check_field("pulse_count", pulse_count, want.count);
		check_field("window_delta", window_delta, want.delta);
		check_field("forward_limit", 32'(forward_limit), 32'(want.fwd_lim));
		check_field("backward_limit", 32'(backward_limit), 32'(want.back_lim));
		check_field("calib_state", 32'(calib_state), 32'(want.phase));
		check_field("track_pulses", track_pulses, want.track);
		checked_i++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DRIVE_DUTY: cfg_duty   = cfg_data[DUTY_W-1:0];
					CFG_TRACK_CM:   cfg_track  = cfg_data[TRACK_W-1:0];
					CFG_MARGIN_CM:  cfg_margin = cfg_data[MARGIN_W-1:0];
					default:        cfg_window = cfg_data[WIN_W-1:0];
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(advance_axis(action, enc_a, enc_b, min_sensor,
					max_sensor));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0)
					report("result transaction with no tick awaiting it");
				else
					compare_result(expected_q.pop_front());
			end
		end
		mismatches   <= err_i;
		pending      <= expected_q.size();
		results_seen <= checked_i;
		homed_runs   <= homed_i;
		calib_faults <= fault_i;
	end

endmodule

// ===== tb/encoder_axis_homing_controller_tb.sv =====
// Testbench top for the encoder axis homing controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module encoder_axis_homing_controller_tb;
	import ehc_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int QUIET_LIMIT = 1000;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index  = CFG_DRIVE_DUTY;
	logic [CFG_DATA_W-1:0]  cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic [2:0]             action     = ACT_SAMPLE;
	logic                   enc_a      = 1'b0;
	logic                   enc_b      = 1'b0;
	logic                   min_sensor = 1'b0;
	logic                   max_sensor = 1'b0;
	logic                   out_stall  = 1'b0;

	logic                   in_stall, out_valid, dir_first, dir_second;
	logic [DUTY_W-1:0]      pwm_duty;
	logic signed [OUT_W-1:0] pulse_count, window_delta, track_pulses;
	logic                   forward_limit, backward_limit;
	logic [2:0]             calib_state;

	int mismatches, pending, results_seen, homed_runs, calib_faults;
	int ticks_sent   = 0;
	int idle_pct     = 0;
	int stall_left   = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	encoder_axis_homing_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .enc_a(enc_a), .enc_b(enc_b),
		.min_sensor(min_sensor), .max_sensor(max_sensor),
		.out_valid(out_valid), .out_stall(out_stall),
		.dir_first(dir_first), .dir_second(dir_second), .pwm_duty(pwm_duty),
		.pulse_count(pulse_count), .window_delta(window_delta),
		.forward_limit(forward_limit), .backward_limit(backward_limit),
		.calib_state(calib_state), .track_pulses(track_pulses)
	);

	ehc_axis_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .enc_a(enc_a), .enc_b(enc_b),
		.min_sensor(min_sensor), .max_sensor(max_sensor),
		.out_valid(out_valid), .out_stall(out_stall),
		.dir_first(dir_first), .dir_second(dir_second), .pwm_duty(pwm_duty),
		.pulse_count(pulse_count), .window_delta(window_delta),
		.forward_limit(forward_limit), .backward_limit(backward_limit),
		.calib_state(calib_state), .track_pulses(track_pulses),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen),
		.homed_runs(homed_runs), .calib_faults(calib_faults)
	);

	// output backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end else if (arst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(1, 11);
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("encoder_axis_homing_controller_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_tick(logic [2:0] act, logic a, logic b, logic mn, logic mx);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		enc_a      <= a;
		enc_b      <= b;
		min_sensor <= mn;
		max_sensor <= mx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ticks_sent++;
	endtask

	// one encoder step: A low then A high, B picks the direction at the edge
	task automatic pulse(logic down, logic mn, logic mx);
		send_tick(ACT_SAMPLE, 1'b0, 1'($urandom_range(0, 1)), mn, mx);
		if ($urandom_range(0, 3) == 0)
			send_tick(ACT_SAMPLE, 1'b0, 1'($urandom_range(0, 1)), mn, mx);
		send_tick(ACT_SAMPLE, 1'b1, down, mn, mx);
		if ($urandom_range(0, 3) == 0)
			send_tick(ACT_SAMPLE, 1'b1, 1'($urandom_range(0, 1)), mn, mx);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// any margin division has finished by the time no result is pending
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int duty, int track_cm, int margin, int window);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_DRIVE_DUTY;
		cfg_data  <= 16'(duty);
		@(posedge clk);
		cfg_index <= CFG_TRACK_CM;
		cfg_data  <= 16'(track_cm);
		@(posedge clk);
		cfg_index <= CFG_MARGIN_CM;
		cfg_data  <= 16'(margin);
		@(posedge clk);
		cfg_index <= CFG_WIN_TICKS;
		cfg_data  <= 16'(window);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(5, 20))
			send_tick(3'($urandom_range(int'(ACT_SAMPLE), int'(ACT_UNUSED))),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic manual_drive();
		send_tick(3'($urandom_range(int'(ACT_FWD), int'(ACT_COAST))),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// seek min, run to max, come back home; some runs get cut short
	task automatic homing_run();
		int  span, back;
		bit  down, cut;
		cut  = ($urandom_range(0, 7) == 0);
		down = ($urandom_range(0, 9) == 0);
		span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 25);
		send_tick(ACT_CAL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
		repeat ($urandom_range(0, 4)) pulse(1'b1, 1'b0, 1'($urandom_range(0, 1)));
		send_tick(ACT_SAMPLE, 1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
		repeat (span) pulse(down, 1'($urandom_range(0, 1)), 1'b0);
		if (cut && $urandom_range(0, 1) == 1) begin
			manual_drive();
		end else begin
			send_tick(ACT_SAMPLE, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'b1);
			back = ($urandom_range(0, 5) == 0) ? span / 2 : span + $urandom_range(0, 3);
			repeat (back) pulse(!down, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (cut)
				manual_drive();
		end
		if ($urandom_range(0, 2) == 0)
			send_tick(ACT_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic run_phase(int duty, int track_cm, int margin, int window, int idle,
			int ticks);
		int stop_at;
		drain();
		set_config(duty, track_cm, margin, window);
		idle_pct = idle;
		stop_at = ticks_sent + ticks;
		while (ticks_sent < stop_at) begin
			if ($urandom_range(0, 9) < 7)
				homing_run();
			else
				noise_burst();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: priming, counting, every action, calibration corners
		send_tick(ACT_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1);
		send_tick(ACT_FWD, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_BACK, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_BRAKE, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(ACT_COAST, 1'b1, 1'b1, 1'b0, 1'b1);
		send_tick(ACT_ZERO, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_UNUSED, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_CAL, 1'b0, 1'b0, 1'b1, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1);
		send_tick(ACT_FWD, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_CAL, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_COAST, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_CAL, 1'b0, 1'b1, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(ACT_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0);
		send_tick(ACT_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b1);
		repeat (3) begin
			send_tick(ACT_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0);
			send_tick(ACT_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0);
		end

		run_phase(1023, 100, 3, 1, 10, 90);
		run_phase(0, 1, 255, 65535, 30, 90);
		run_phase(700, 65535, 0, 7, 0, 90);
		run_phase(333, 0, 10, 3, 15, 80);
		run_phase(512, 10, 255, 200, 20, 90);
		run_phase($urandom_range(0, 1023), $urandom_range(1, 50), $urandom_range(0, 255),
			$urandom_range(1, 40), 25, 100);
		run_phase($urandom_range(0, 1023), $urandom_range(1, 65535), $urandom_range(0, 255),
			$urandom_range(1, 65535), 10, 100);
		// no idling on either side for the tail of the run
		run_phase(900, 7, 2, 13, 0, 110);
		drain();

		$display("%0d ticks driven, %0d results checked over 9 register settings",
			ticks_sent, results_seen);
		$display("%0d homing runs reached ready, %0d ended in calibration error",
			homed_runs, calib_faults);
		if (mismatches == 0)
			$display("encoder_axis_homing_controller_tb OK");
		else
			$display("encoder_axis_homing_controller_tb NOT OK");
		$finish;
	end

endmodule
